[src/dlr_pkg.sv]
// Shared constants, types and helpers for the DDA line rasterizer.
// No dependencies; every other file refers to this package by scoped names.
package dlr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COLOR_BITS     = 24;
    localparam int QUEUE_DEPTH    = 2;

    // action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // status of the command queue as seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_qflags;

    // command word: action, sx, sy, adx, ady, steps, neg_x, neg_y, color
    function automatic int cmd_bits(input int coord_bits);
        return 1 + 5 * coord_bits + 2 + COLOR_BITS;
    endfunction

endpackage

[src/dlr_front.sv]
// Front part: takes input items, works out deltas, signs and the step count.
// Depends on dlr_pkg; feeds dlr_queue.
module dlr_front #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_action,
    input  logic [COORD_BITS-1:0]          i_start_x,
    input  logic [COORD_BITS-1:0]          i_start_y,
    input  logic [COORD_BITS-1:0]          i_end_x,
    input  logic [COORD_BITS-1:0]          i_end_y,
    input  logic [dlr_pkg::COLOR_BITS-1:0] i_color,
    input  dlr_pkg::t_qflags               i_qflags,
    output logic                           o_q_push,
    output logic [dlr_pkg::cmd_bits(COORD_BITS)-1:0] o_q_data
);

    localparam int CMD_W = dlr_pkg::cmd_bits(COORD_BITS);

    logic             r_valid, n_valid;
    logic [CMD_W-1:0] r_cmd;
    logic             accept;
    logic             neg_x, neg_y;
    logic [COORD_BITS-1:0] adx, ady, steps;

    assign o_q_push = r_valid && !i_qflags.full;
    assign o_full   = r_valid && i_qflags.full;
    assign accept   = i_push && !o_full;
    assign o_q_data = r_cmd;

    always_comb begin
        neg_x = i_end_x < i_start_x;
        neg_y = i_end_y < i_start_y;
        adx   = neg_x ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady   = neg_y ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        steps = (adx > ady) ? adx : ady;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_q_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= {i_action, i_start_x, i_start_y, adx, ady, steps,
                      neg_x, neg_y, i_color};
        end
    end

endmodule

[src/dlr_queue.sv]
// Short register queue between the front and back parts.
// Depends on dlr_pkg for the status struct.
module dlr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dlr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output dlr_pkg::t_qflags o_flags
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_flags.full  = (r_cnt == CNT_FULL);
    assign o_flags.empty = (r_cnt == '0);
    assign do_push = i_push && !o_flags.full;
    assign do_pop  = i_pop && !o_flags.empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/dlr_back.sv]
// Back part: line state, iterative increment divider, stepping, result register.
// Depends on dlr_pkg; fed by dlr_queue.
module dlr_back #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dlr_pkg::cmd_bits(COORD_BITS)-1:0] i_q_data,
    input  dlr_pkg::t_qflags               i_qflags,
    output logic                           o_q_pop,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PB    = C + F;
    localparam int IB    = F + 2;
    localparam int DCW   = $clog2(F + 1);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(F);
    localparam logic [F-1:0]   HALF     = {1'b1, {(F-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    // unpacked command
    logic                           c_action, c_neg_x, c_neg_y;
    logic [C-1:0]                   c_sx, c_sy, c_adx, c_ady, c_steps;
    logic [dlr_pkg::COLOR_BITS-1:0] c_color;

    assign {c_action, c_sx, c_sy, c_adx, c_ady, c_steps, c_neg_x, c_neg_y, c_color} = i_q_data;

    t_state  r_state, n_state;
    logic    r_active, n_active;
    logic [PB-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;   // position plus one half
    logic [IB-1:0] r_inc_x, n_inc_x, r_inc_y, n_inc_y;
    logic [C-1:0]  r_steps, n_steps;
    logic [dlr_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic [C:0]    r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic [F:0]    r_q_x, n_q_x, r_q_y, n_q_y;
    logic          r_neg_x, n_neg_x, r_neg_y, n_neg_y;
    logic [DCW-1:0] r_cnt, n_cnt;

    logic          r_out_valid, n_out_valid;
    logic [C-1:0]  r_out_x, n_out_x, r_out_y, n_out_y;
    logic [dlr_pkg::COLOR_BITS-1:0] r_out_color, n_out_color;
    logic          r_out_last, n_out_last;

    logic          out_free;
    logic [C:0]    t_x, t_y;
    logic          ge_x, ge_y;
    logic [PB-1:0] adv_x, adv_y;

    assign out_free      = !r_out_valid || i_pop;
    assign o_empty       = !r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last        = r_out_last;

    // one restoring-division step for each axis, and the advanced positions
    always_comb begin
        t_x  = (r_cnt == '0) ? r_rem_x : {r_rem_x[C-1:0], 1'b0};
        t_y  = (r_cnt == '0) ? r_rem_y : {r_rem_y[C-1:0], 1'b0};
        ge_x = t_x >= {1'b0, r_steps};
        ge_y = t_y >= {1'b0, r_steps};
        adv_x = r_pos_x + {{(PB-IB){r_inc_x[IB-1]}}, r_inc_x};
        adv_y = r_pos_y + {{(PB-IB){r_inc_y[IB-1]}}, r_inc_y};
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_inc_x     = r_inc_x;
        n_inc_y     = r_inc_y;
        n_steps     = r_steps;
        n_color     = r_color;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_q_x       = r_q_x;
        n_q_y       = r_q_y;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_pop;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_qflags.empty) begin
                    if (c_action == dlr_pkg::ACT_ADVANCE) begin
                        if (!r_active) begin
                            o_q_pop = 1'b1;             // drop: no line to advance
                        end else if (out_free) begin
                            o_q_pop     = 1'b1;
                            n_pos_x     = adv_x;
                            n_pos_y     = adv_y;
                            n_steps     = r_steps - C'(1);
                            n_active    = (r_steps != C'(1));
                            n_out_valid = 1'b1;
                            n_out_x     = adv_x[PB-1:F];
                            n_out_y     = adv_y[PB-1:F];
                            n_out_color = r_color;
                            n_out_last  = (r_steps == C'(1));
                        end
                    end else if (out_free) begin
                        o_q_pop     = 1'b1;
                        n_pos_x     = {c_sx, HALF};
                        n_pos_y     = {c_sy, HALF};
                        n_steps     = c_steps;
                        n_color     = c_color;
                        n_neg_x     = c_neg_x;
                        n_neg_y     = c_neg_y;
                        n_rem_x     = {1'b0, c_adx};
                        n_rem_y     = {1'b0, c_ady};
                        n_cnt       = '0;
                        n_out_valid = 1'b1;
                        n_out_x     = c_sx;
                        n_out_y     = c_sy;
                        n_out_color = c_color;
                        n_out_last  = (c_steps == '0);
                        n_active    = (c_steps != '0);
                        if (c_steps != '0) begin
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem_x = ge_x ? (t_x - {1'b0, r_steps}) : t_x;
                n_rem_y = ge_y ? (t_y - {1'b0, r_steps}) : t_y;
                n_q_x   = {r_q_x[F-1:0], ge_x};
                n_q_y   = {r_q_y[F-1:0], ge_y};
                n_cnt   = r_cnt + DCW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_inc_x = r_neg_x ? (IB'(0) - {1'b0, n_q_x}) : {1'b0, n_q_x};
                    n_inc_y = r_neg_y ? (IB'(0) - {1'b0, n_q_y}) : {1'b0, n_q_y};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x     <= n_pos_x;
        r_pos_y     <= n_pos_y;
        r_inc_x     <= n_inc_x;
        r_inc_y     <= n_inc_y;
        r_steps     <= n_steps;
        r_color     <= n_color;
        r_rem_x     <= n_rem_x;
        r_rem_y     <= n_rem_y;
        r_q_x       <= n_q_x;
        r_q_y       <= n_q_y;
        r_neg_x     <= n_neg_x;
        r_neg_y     <= n_neg_y;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

endmodule

[src/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer: front part, command queue, back part.
// Depends on dlr_pkg, dlr_front, dlr_queue and dlr_back.
//
//   channel   handshake                    payload
//   -------   --------------------------   ----------------------------------------------
//   input     push / full (take on !full)  i_action, i_start_x/y, i_end_x/y, i_color
//   result    empty / pop (take on !empty) o_pixel_x, o_pixel_y, o_pixel_color, o_last
//
// An advance on an active line produces one pixel per cycle once it reaches the back part,
// while the result register is free or popped. A start puts its first pixel in the result
// register, then holds the back part while the per-axis restoring dividers form both
// increments, one quotient bit per cycle. Items pass a front register and a QUEUE_DEPTH-entry
// queue first, so the front keeps taking items during a division until the queue fills. Reset
// is synchronous and empties both sides; the line state itself needs no clearing pass.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_action,
    input  logic [COORD_BITS-1:0]          i_start_x,
    input  logic [COORD_BITS-1:0]          i_start_y,
    input  logic [COORD_BITS-1:0]          i_end_x,
    input  logic [COORD_BITS-1:0]          i_end_y,
    input  logic [dlr_pkg::COLOR_BITS-1:0] i_color,
    output logic                           empty,
    input  logic                           pop,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last
);

    localparam int CMD_W = dlr_pkg::cmd_bits(COORD_BITS);

    dlr_pkg::t_qflags  qflags;
    logic              q_push, q_pop;
    logic [CMD_W-1:0]  q_wdata, q_rdata;

    // classify each item and register it ahead of the queue
    dlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_action  (i_action),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_color   (i_color),
        .i_qflags  (qflags),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // decouple the front from a back part busy dividing or stalled on output
    dlr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (dlr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_flags (qflags)
    );

    // run lines: divide on start, step on advance, hold the result register
    dlr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_rdata),
        .i_qflags      (qflags),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

endmodule

[src/dlr_checker.sv]
// Port-level checks for the DDA line rasterizer, attached by bind.
// Depends on dlr_pkg and the top level dda_line_rasterizer.
module dlr_checker #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [COORD_BITS-1:0]          o_pixel_x,
    input logic [COORD_BITS-1:0]          o_pixel_y,
    input logic [dlr_pkg::COLOR_BITS-1:0] o_pixel_color,
    input logic                           o_last
);

    // transactions taken in but not yet answered; sticks once it saturates
    logic [15:0] r_pending;
    logic        in_txn, out_txn;

    assign in_txn  = push && !full;
    assign out_txn = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (r_pending != '1) begin
            r_pending <= r_pending + 16'(in_txn) - 16'(out_txn);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_x) && $stable(o_pixel_y)
                              && $stable(o_pixel_color) && $stable(o_last)))
        else $error("waiting result changed or vanished");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_txn |-> (r_pending != '0))
        else $error("result delivered without a matching input transaction");

endmodule

bind dda_line_rasterizer dlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlr_checker (.*);

[dv/dda_line_rasterizer_tb.sv]
// Self-checking testbench for dda_line_rasterizer: directed table, then random line traffic.
// Depends on dlr_pkg and the dda_line_rasterizer RTL; carries its own line-stepping predictor.
module dda_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = dlr_pkg::COORD_BITS_DEF;
    localparam int FRAC_W    = dlr_pkg::FRAC_BITS_DEF;
    localparam int COLOR_W   = dlr_pkg::COLOR_BITS;
    localparam int POS_W     = COORD_W + FRAC_W;
    localparam int INC_W     = FRAC_W + 2;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    localparam logic ACT_START   = dlr_pkg::ACT_START;
    localparam logic ACT_ADVANCE = dlr_pkg::ACT_ADVANCE;

    // One half in position units, added before truncating to a pixel.
    localparam logic [POS_W:0] ROUND_HALF = (POS_W + 1)'(1) << (FRAC_W - 1);

    // Counted (pixel-producing) transactions per random phase; three phases.
    localparam int PHASE_ITEMS = 285;
    // Cycles with no transaction on either side before the run is declared hung.
    // A start holds the back end while the increments are divided; receiver stalls add more.
    localparam int STALL_LIMIT = 4000;
    // Quiet time after the last pixel, to catch anything extra the block emits.
    localparam int SETTLE_CYCLES = 4 * (FRAC_W + 1) + 16;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COLOR_W-1:0] color;
    } t_line_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    // How a table row gets its expectation: from the predictor, typed in, or none at all.
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_PIXEL
    } t_exp_kind;

    typedef struct {
        t_line_cmd cmd;
        t_exp_kind kind;
        t_pixel    pix;
    } t_row;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_action;
    logic [COORD_W-1:0] i_start_x;
    logic [COORD_W-1:0] i_start_y;
    logic [COORD_W-1:0] i_end_x;
    logic [COORD_W-1:0] i_end_y;
    logic [COLOR_W-1:0] i_color;
    logic               empty;
    logic               pop = 1'b0;
    logic [COORD_W-1:0] o_pixel_x;
    logic [COORD_W-1:0] o_pixel_y;
    logic [COLOR_W-1:0] o_pixel_color;
    logic               o_last;

    dda_line_rasterizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_color       (i_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the line currently being stepped
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   ln_pos_x      = '0;
    logic [POS_W-1:0]   ln_pos_y      = '0;
    logic [INC_W-1:0]   ln_inc_x      = '0;
    logic [INC_W-1:0]   ln_inc_y      = '0;
    logic [COORD_W:0]   ln_steps_left = '0;
    logic               ln_active     = 1'b0;
    logic [COLOR_W-1:0] ln_color      = '0;

    t_pixel pending_pixels[$];   // pixels owed by the block, oldest first
    int     pixels_drawn  = 0;   // accepted transactions that produce a pixel
    int     failures      = 0;
    int     send_idle_pct = 11;
    int     recv_idle_pct = 57;
    int     stall_cycles  = 0;

    // Signed Q1.FRAC increment, truncated toward zero.
    function automatic logic [INC_W-1:0] step_increment(input logic [COORD_W-1:0] a,
                                                        input logic [COORD_W-1:0] b,
                                                        input logic [COORD_W:0]   steps);
        logic [COORD_W-1:0] mag;
        logic [POS_W-1:0]   q;
        mag = (b >= a) ? b - a : a - b;
        q   = {mag, {FRAC_W{1'b0}}} / steps;
        if (b < a)
            q = -q;
        return q[INC_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] round_coord(input logic [POS_W-1:0] pos);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + ROUND_HALF;
        return sum[POS_W-1:FRAC_W];
    endfunction

    function automatic t_pixel pixel_here(input logic is_last);
        t_pixel px;
        px.x     = round_coord(ln_pos_x);
        px.y     = round_coord(ln_pos_y);
        px.color = ln_color;
        px.last  = is_last;
        return px;
    endfunction

    // Advance the predicted line by one transaction; returns 1 when a pixel comes out.
    function automatic bit rasterize_step(input t_line_cmd cmd, output t_pixel px);
        logic [COORD_W-1:0] adx;
        logic [COORD_W-1:0] ady;
        logic [COORD_W:0]   steps;
        px = '0;
        if (cmd.action == ACT_START) begin
            adx      = (cmd.ex >= cmd.sx) ? cmd.ex - cmd.sx : cmd.sx - cmd.ex;
            ady      = (cmd.ey >= cmd.sy) ? cmd.ey - cmd.sy : cmd.sy - cmd.ey;
            steps    = (adx > ady) ? {1'b0, adx} : {1'b0, ady};
            ln_color = cmd.color;
            ln_pos_x = {cmd.sx, {FRAC_W{1'b0}}};
            ln_pos_y = {cmd.sy, {FRAC_W{1'b0}}};
            if (steps == '0) begin
                // degenerate line: a single pixel, already the last
                ln_inc_x      = '0;
                ln_inc_y      = '0;
                ln_steps_left = '0;
                ln_active     = 1'b0;
                px            = pixel_here(1'b1);
                return 1'b1;
            end
            ln_inc_x      = step_increment(cmd.sx, cmd.ex, steps);
            ln_inc_y      = step_increment(cmd.sy, cmd.ey, steps);
            ln_steps_left = steps;
            ln_active     = 1'b1;
            px            = pixel_here(1'b0);
            return 1'b1;
        end
        if (!ln_active)
            return 1'b0;
        ln_pos_x      = ln_pos_x + {{(POS_W - INC_W){ln_inc_x[INC_W-1]}}, ln_inc_x};
        ln_pos_y      = ln_pos_y + {{(POS_W - INC_W){ln_inc_y[INC_W-1]}}, ln_inc_y};
        ln_steps_left = ln_steps_left - 1'b1;
        ln_active     = (ln_steps_left != '0);
        px            = pixel_here(!ln_active);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed expectations only where obvious by inspection:
    // idle advances, degenerate lines, first pixels and unit-slope steps.
    // ------------------------------------------------------------------
    t_row directed_rows[$] = '{
        // advance right after reset: no line, nothing out (ignored fields at max)
        '{'{ACT_ADVANCE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF},
          EXP_NONE,  '0},
        // equal endpoints at both corners: one pixel, marked last
        '{'{ACT_START,   10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_PIXEL, '{10'd0,    10'd0,    24'h000000, 1'b1}},
        '{'{ACT_START,   10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF},
          EXP_PIXEL, '{10'd1023, 10'd1023, 24'hFFFFFF, 1'b1}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_NONE,  '0},
        // one-step line, then an advance past its end
        '{'{ACT_START,   10'd0,    10'd0,    10'd1,    10'd0,    24'h123456},
          EXP_PIXEL, '{10'd0,    10'd0,    24'h123456, 1'b0}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_PIXEL, '{10'd1,    10'd0,    24'h123456, 1'b1}},
        '{'{ACT_ADVANCE, 10'd5,    10'd5,    10'd5,    10'd5,    24'h555555},
          EXP_NONE,  '0},
        // full diagonal, increments of exactly one pixel
        '{'{ACT_START,   10'd0,    10'd0,    10'd1023, 10'd1023, 24'hFFFFFF},
          EXP_PIXEL, '{10'd0,    10'd0,    24'hFFFFFF, 1'b0}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_PIXEL, '{10'd1,    10'd1,    24'hFFFFFF, 1'b0}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_PIXEL, '{10'd2,    10'd2,    24'hFFFFFF, 1'b0}},
        // start over an active line: abandon it, run the reverse diagonal
        '{'{ACT_START,   10'd1023, 10'd1023, 10'd0,    10'd0,    24'hA5A5A5},
          EXP_PIXEL, '{10'd1023, 10'd1023, 24'hA5A5A5, 1'b0}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_PIXEL, '{10'd1022, 10'd1022, 24'hA5A5A5, 1'b0}},
        // anti-diagonal, mixed signs
        '{'{ACT_START,   10'd1023, 10'd0,    10'd0,    10'd1023, 24'h5A5A5A},
          EXP_PIXEL, '{10'd1023, 10'd0,    24'h5A5A5A, 1'b0}},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000},
          EXP_MODEL, '0},
        // steep line with a fractional, negative x increment, run to the end
        '{'{ACT_START,   10'd3,    10'd700,  10'd0,    10'd709,  24'h0F0F0F},
          EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_MODEL, '0},
        '{'{ACT_ADVANCE, 10'd0,    10'd0,    10'd0,    10'd0,    24'h000000}, EXP_NONE,  '0}
    };

    // ------------------------------------------------------------------
    // Sender side. Called just after a falling edge; returns just after the
    // falling edge that follows acceptance, with push still high.
    // ------------------------------------------------------------------
    task automatic drive_item(input t_line_cmd cmd, input t_exp_kind kind, input t_pixel typed);
        t_pixel px;
        bit     made;
        // random gap before the transaction
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push      = 1'b1;
        i_action  = cmd.action;
        i_start_x = cmd.sx;
        i_start_y = cmd.sy;
        i_end_x   = cmd.ex;
        i_end_y   = cmd.ey;
        i_color   = cmd.color;
        // hold until the queue has room at a rising edge
        do
            @(posedge i_clk);
        while (full);
        made = rasterize_step(cmd, px);
        if (made)
            pixels_drawn++;
        case (kind)
            EXP_MODEL: if (made) pending_pixels.push_back(px);
            EXP_PIXEL: pending_pixels.push_back(typed);
            default:   ;
        endcase
        @(negedge i_clk);
    endtask

    // Drop push and hold off until every owed pixel has been taken.
    task automatic wait_all_drawn();
        push = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    // One random line: a start and a run of advances. Most lines are short
    // and run exactly to their last pixel; some are abandoned midway, some
    // get stray advances after the end, a few join random points anywhere on the field.
    task automatic draw_random_line();
        int        sx;
        int        sy;
        int        dx;
        int        dy;
        int        steps;
        int        n_adv;
        int        shape;
        int        runout;
        t_line_cmd cmd;
        if ($urandom_range(99) < 3)
            wait_all_drawn();
        shape = $urandom_range(99);
        sx    = $urandom_range(COORD_MAX);
        sy    = $urandom_range(COORD_MAX);
        if (shape < 4) begin
            dx = int'($urandom_range(COORD_MAX)) - sx;
            dy = int'($urandom_range(COORD_MAX)) - sy;
        end else if (shape < 9) begin
            dx = 0;
            dy = 0;
        end else begin
            dx = $urandom_range(24);
            dy = $urandom_range(24);
            if ($urandom_range(1)) dx = -dx;
            if ($urandom_range(1)) dy = -dy;
            // keep the far endpoint on the field
            if (sx + dx > COORD_MAX || sx + dx < 0) dx = -dx;
            if (sy + dy > COORD_MAX || sy + dy < 0) dy = -dy;
        end
        steps = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > steps)
            steps = (dy < 0) ? -dy : dy;

        runout = $urandom_range(99);
        if (shape < 4) begin
            n_adv = $urandom_range(40);
            if (n_adv > steps)
                n_adv = steps;
        end else if (runout < 80) begin
            n_adv = steps;
        end else if (runout < 90) begin
            n_adv = $urandom_range(steps);
        end else begin
            n_adv = steps + $urandom_range(1, 3);
        end

        cmd.action = ACT_START;
        cmd.sx     = COORD_W'(sx);
        cmd.sy     = COORD_W'(sy);
        cmd.ex     = COORD_W'(sx + dx);
        cmd.ey     = COORD_W'(sy + dy);
        cmd.color  = COLOR_W'($urandom);
        drive_item(cmd, EXP_MODEL, '0);
        repeat (n_adv) begin
            // endpoint and colour fields are don't-care on an advance; scramble them
            cmd.action = ACT_ADVANCE;
            cmd.sx     = COORD_W'($urandom);
            cmd.sy     = COORD_W'($urandom);
            cmd.ex     = COORD_W'($urandom);
            cmd.ey     = COORD_W'($urandom);
            cmd.color  = COLOR_W'($urandom);
            drive_item(cmd, EXP_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random pop decided at the falling edge, result checked
    // at the rising edge against the oldest owed pixel.
    // ------------------------------------------------------------------
    always @(negedge i_clk)
        pop = ($urandom_range(99) >= recv_idle_pct);

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel (%0d,%0d) color %06h last %0b arrived with nothing owed",
                       o_pixel_x, o_pixel_y, o_pixel_color, o_last);
                failures++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("pixel_x",     want.x,     o_pixel_x);
                compare_field("pixel_y",     want.y,     o_pixel_y);
                compare_field("pixel_color", want.color, o_pixel_color);
                compare_field("last",        want.last,  o_last);
            end
        end
    end

    // Hang detector: count edges with no transaction on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run
        int phase_target;
        push      = 1'b0;
        i_action  = ACT_START;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x   = '0;
        i_end_y   = '0;
        i_color   = '0;
        i_rst_n   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table under the first idling mix
        foreach (directed_rows[i])
            drive_item(directed_rows[i].cmd, directed_rows[i].kind, directed_rows[i].pix);
        wait_all_drawn();

        // random traffic in three idling mixes: slow receiver, slow sender, none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 11; recv_idle_pct = 57; end
                1:       begin send_idle_pct = 57; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            phase_target = pixels_drawn + PHASE_ITEMS;
            while (pixels_drawn < phase_target)
                draw_random_line();
            wait_all_drawn();
        end

        // drain, then give the block time to show any stray pixel
        push = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
src/dlr_pkg.sv
src/dlr_front.sv
src/dlr_queue.sv
src/dlr_back.sv
src/dda_line_rasterizer.sv
src/dlr_checker.sv
dv/dda_line_rasterizer_tb.sv
